/* rtl/core/tpf_pkg.sv */
package tpf_pkg;

    // Frame layout
    localparam int FRONT_SLOTS      = 6;
    localparam int BACK_SLOTS       = 4;
    localparam int SLOTS_PER_REGION = 10;
    localparam int HEADER_BYTES     = 4;
    localparam int SLOT_SIZE        = 6;

    // Slot counter reaches at most (255 - HEADER_BYTES) / SLOT_SIZE
    localparam int SLOT_W   = 6;
    localparam int K_W      = 3;
    localparam int POS_W    = 8;

    localparam logic [POS_W-1:0]  POS_MAX      = 8'hFF;
    localparam logic [POS_W-1:0]  HEADER_POS   = POS_W'(HEADER_BYTES);
    localparam logic [K_W-1:0]    K_FORCE      = K_W'(SLOT_SIZE - 1);
    localparam logic [SLOT_W-1:0] FRONT_END    = SLOT_W'(FRONT_SLOTS);
    localparam logic [SLOT_W-1:0] BACK_START   = SLOT_W'(SLOTS_PER_REGION);
    localparam logic [SLOT_W-1:0] BACK_END     = SLOT_W'(SLOTS_PER_REGION + BACK_SLOTS);

    localparam logic [2:0] FRONT_COUNT_MAX = 3'd7;
    localparam int         INVALID_BIT     = 7;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam int TDATA_W = 40;

    typedef enum logic [1:0] {
        EV_TOUCH   = 2'd0,
        EV_MOVE    = 2'd1,
        EV_PRESS   = 2'd2,
        EV_RELEASE = 2'd3
    } event_kind_t;

    typedef struct packed {
        event_kind_t kind;
        logic        panel;
        logic [6:0]  touch_id;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [7:0]  pressure;
        logic        last;
    } result_t;

    // Up to two results per item; res1 is used only together with res0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

/* rtl/core/tpf_parser.sv */
module tpf_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  frame_end,
    input  logic                  panel_en_we,
    input  logic [1:0]            panel_en_wdata,
    output tpf_pkg::push_t        push
);

    logic [1:0]                      panel_en_reg;
    logic [tpf_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [tpf_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [tpf_pkg::K_W-1:0]         k_reg, k_next;
    logic [4:0][7:0]                 slot_bytes_reg, slot_bytes_next;
    logic [10:0]                     fft_x_reg, fft_x_next;
    logic [10:0]                     fft_y_reg, fft_y_next;
    logic [7:0]                      fft_p_reg, fft_p_next;
    logic [2:0]                      front_count_reg, front_count_next;
    logic                            pen_down_reg, pen_down_next;

    logic        in_payload;
    logic        is_front;
    logic        is_back;
    logic        enabled;
    logic        touch_v;
    logic        ptr_v;
    logic [10:0] x;
    logic [10:0] y;
    tpf_pkg::result_t touch_res;
    tpf_pkg::result_t ptr_res;

    always_comb
    begin
        in_payload = pos_reg >= tpf_pkg::HEADER_POS;
        is_front   = slot_reg < tpf_pkg::FRONT_END;
        is_back    = !is_front && (slot_reg >= tpf_pkg::BACK_START)
                     && (slot_reg < tpf_pkg::BACK_END);
        enabled    = (is_front && panel_en_reg[0]) || (is_back && panel_en_reg[1]);
        x          = {slot_bytes_reg[2][2:0], slot_bytes_reg[1]};
        y          = {slot_bytes_reg[4][2:0], slot_bytes_reg[3]};
        touch_v    = accept && in_payload && (k_reg == tpf_pkg::K_FORCE) && enabled
                     && !slot_bytes_reg[0][tpf_pkg::INVALID_BIT];

        slot_bytes_next  = slot_bytes_reg;
        front_count_next = front_count_reg;
        fft_x_next       = fft_x_reg;
        fft_y_next       = fft_y_reg;
        fft_p_next       = fft_p_reg;
        pen_down_next    = pen_down_reg;
        pos_next         = pos_reg;
        slot_next        = slot_reg;
        k_next           = k_reg;

        // Capture id and coordinate bytes of the slot
        if (accept && in_payload)
        begin
            for (int i = 0; i < 5; i++)
            begin
                if (k_reg == tpf_pkg::K_W'(i))
                begin
                    slot_bytes_next[i] = data_byte;
                end
            end
        end

        // Record the first front report and count front reports
        if (touch_v && is_front)
        begin
            if (front_count_reg == 3'd0)
            begin
                fft_x_next = x;
                fft_y_next = y;
                fft_p_next = data_byte;
            end
            if (front_count_reg != tpf_pkg::FRONT_COUNT_MAX)
            begin
                front_count_next = front_count_reg + 3'd1;
            end
        end

        // Advance position; slot and offset freeze once the position saturates
        if (accept && (pos_reg != tpf_pkg::POS_MAX))
        begin
            pos_next = pos_reg + 8'd1;
            if (in_payload)
            begin
                if (k_reg == tpf_pkg::K_FORCE)
                begin
                    k_next    = '0;
                    slot_next = slot_reg + 6'd1;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
        end

        touch_res.kind     = tpf_pkg::EV_TOUCH;
        touch_res.panel    = is_back;
        touch_res.touch_id = slot_bytes_reg[0][6:0];
        touch_res.pos_x    = x;
        touch_res.pos_y    = y;
        touch_res.pressure = data_byte;
        touch_res.last     = 1'b1;

        ptr_v            = 1'b0;
        ptr_res.kind     = tpf_pkg::EV_RELEASE;
        ptr_res.panel    = 1'b0;
        ptr_res.touch_id = '0;
        ptr_res.pos_x    = '0;
        ptr_res.pos_y    = '0;
        ptr_res.pressure = '0;
        ptr_res.last     = 1'b1;

        if (accept && frame_end)
        begin
            if (front_count_next != 3'd0)
            begin
                ptr_v            = 1'b1;
                ptr_res.kind     = pen_down_reg ? tpf_pkg::EV_MOVE : tpf_pkg::EV_PRESS;
                ptr_res.pos_x    = fft_x_next;
                ptr_res.pos_y    = fft_y_next;
                ptr_res.pressure = fft_p_next;
                pen_down_next    = 1'b1;
            end
            else if (pen_down_reg)
            begin
                ptr_v         = 1'b1;
                pen_down_next = 1'b0;
            end
            pos_next         = '0;
            slot_next        = '0;
            k_next           = '0;
            front_count_next = '0;
            fft_x_next       = '0;
            fft_y_next       = '0;
            fft_p_next       = '0;
        end

        // Touch report is not last when a pointer event follows it
        touch_res.last = !ptr_v;

        push.v0   = touch_v || ptr_v;
        push.v1   = touch_v && ptr_v;
        push.res0 = touch_v ? touch_res : ptr_res;
        push.res1 = ptr_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_en_reg    <= 2'd3;
            pos_reg         <= '0;
            slot_reg        <= '0;
            k_reg           <= '0;
            slot_bytes_reg  <= '0;
            fft_x_reg       <= '0;
            fft_y_reg       <= '0;
            fft_p_reg       <= '0;
            front_count_reg <= '0;
            pen_down_reg    <= 1'b0;
        end
        else
        begin
            if (panel_en_we)
            begin
                panel_en_reg <= panel_en_wdata;
            end
            pos_reg         <= pos_next;
            slot_reg        <= slot_next;
            k_reg           <= k_next;
            slot_bytes_reg  <= slot_bytes_next;
            fft_x_reg       <= fft_x_next;
            fft_y_reg       <= fft_y_next;
            fft_p_reg       <= fft_p_next;
            front_count_reg <= front_count_next;
            pen_down_reg    <= pen_down_next;
        end
    end

    a_ptr_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push.v0 && (push.res0.kind != tpf_pkg::EV_TOUCH)) |-> (accept && frame_end))
        else $error("pointer event without frame end");

endmodule

/* rtl/core/tpf_out_fifo.sv */
module tpf_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  tpf_pkg::push_t    push,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output tpf_pkg::result_t  out_res
);

    tpf_pkg::result_t                mem_reg [tpf_pkg::FIFO_DEPTH];
    logic [tpf_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tpf_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tpf_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [tpf_pkg::FIFO_CNT_W-1:0]  push_n;
    logic                            pop;

    always_comb
    begin
        pop         = out_valid && out_ready;
        push_n      = tpf_pkg::FIFO_CNT_W'(push.v0) + tpf_pkg::FIFO_CNT_W'(push.v1);
        wr_ptr_next = wr_ptr_reg + push_n[tpf_pkg::FIFO_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + tpf_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + push_n - tpf_pkg::FIFO_CNT_W'(pop);
    end

    assign ready     = count_reg <= tpf_pkg::FIFO_CNT_W'(tpf_pkg::FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_reg + tpf_pkg::FIFO_PTR_W'(1)] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> (count_reg <= tpf_pkg::FIFO_CNT_W'(tpf_pkg::FIFO_DEPTH - 2)))
        else $error("result pushed without room for two");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result without first");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.v0) |=> (count_reg == $past(count_reg) - 3'd1))
        else $error("queue count lost track of a pop");

endmodule

/* rtl/core/touch_report_frame_parser_top.sv */
// Results of an accepted item are written into the registered result queue and leave on m_axis from its head.
// Throughput: one input item per cycle while s_axis_tready is high; each item yields zero to two results,
// drained one per cycle while m_axis_tready is high, through a four-entry result queue.
// s_axis_tready is high while at least two queue entries are free.
// Reset (rst_n low, asynchronous) empties the queue, clears frame state and pen
// state, and sets the panel enable register to 3 (front and back parsing enabled).
module touch_report_frame_parser_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Input bytes of the response frame
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  logic                         s_axis_tlast,   // frame_end
    // Touch reports and pointer events
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [tpf_pkg::TDATA_W-1:0]  m_axis_tdata,   // [0] panel, [7:1] touch_id,
                                                         // [18:8] pos_x, [29:19] pos_y,
                                                         // [37:30] pressure, [39:38] zero
    output logic [1:0]                   m_axis_tuser,   // [1:0] event_kind
    output logic                         m_axis_tlast,   // last result of the item
    // Configuration
    input  logic                         panel_en_we,
    input  logic [1:0]                   panel_en_wdata
);

    logic             accept;
    tpf_pkg::push_t   push;
    tpf_pkg::result_t head;

    // Take an item whenever the queue can absorb the worst case of two results
    assign accept = s_axis_tvalid && s_axis_tready;

    // Per-byte decode: slot tracking, touch reports and the frame-end pointer event
    tpf_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (s_axis_tdata),
        .frame_end      (s_axis_tlast),
        .panel_en_we    (panel_en_we),
        .panel_en_wdata (panel_en_wdata),
        .push           (push)
    );

    // Result queue: parts the input side from a stalled output side
    tpf_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (head)
    );

    // Pack the head result onto the output bus
    assign m_axis_tdata = {2'b00, head.pressure, head.pos_y, head.pos_x,
                           head.touch_id, head.panel};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    a_empty_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while no result waits");

endmodule
